[hdl/dual_pol_detect_integrate_macros.svh]
// Assertion macros shared by the detector modules.
`ifndef DUAL_POL_DETECT_INTEGRATE_MACROS_SVH
`define DUAL_POL_DETECT_INTEGRATE_MACROS_SVH

// Condition checked at every clock edge outside reset.
`define DPDI_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication.
`define DPDI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DPDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/dpdi_pkg.sv]
`default_nettype none

package dpdi_pkg;

    localparam int unsigned SAMPLE_WIDTH_DEF    = 16;
    localparam int unsigned MAX_INTEGRATION_DEF = 256;

    localparam int unsigned CFG_W = 9;
    localparam logic [CFG_W-1:0] CFG_LEN_RESET = 9'd8;

    localparam int unsigned POWER_W = 40;
    localparam int unsigned CROSS_W = 41;

    localparam int unsigned NUM_PROD = 8;
    localparam int unsigned PROD_AA  = 0;
    localparam int unsigned PROD_BB  = 1;
    localparam int unsigned PROD_CC  = 2;
    localparam int unsigned PROD_DD  = 3;
    localparam int unsigned PROD_AC  = 4;
    localparam int unsigned PROD_BD  = 5;
    localparam int unsigned PROD_BC  = 6;
    localparam int unsigned PROD_AD  = 7;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

`default_nettype wire

[hdl/dpdi_front.sv]
`default_nettype none
`include "dual_pol_detect_integrate_macros.svh"

module dpdi_front import dpdi_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int unsigned MAX_INTEGRATION = MAX_INTEGRATION_DEF,
    localparam int unsigned PROD_W = 2 * SAMPLE_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [CFG_W-1:0]               cfg_len,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_first_pol_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_first_pol_imag,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_second_pol_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_second_pol_imag,
    input  wire logic                           prod_take,
    output stage_ctl_t                          prod_ctl,
    output logic signed [PROD_W-1:0]            prod [NUM_PROD]
);

    localparam int unsigned CNT_W = (MAX_INTEGRATION > 1) ? $clog2(MAX_INTEGRATION) : 1;
    localparam int unsigned LEN_LOG = $clog2(MAX_INTEGRATION + 1);
    localparam int unsigned LEN_W = (LEN_LOG > CFG_W) ? LEN_LOG : CFG_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INTEGRATION);
    localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

    logic                           in_valid_reg, in_valid_next;
    logic                           in_last_reg;
    logic signed [SAMPLE_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           prod_valid_reg, prod_valid_next;
    logic                           prod_last_reg;
    logic signed [PROD_W-1:0]       prod_reg  [NUM_PROD];
    logic signed [PROD_W-1:0]       prod_next [NUM_PROD];
    logic signed [PROD_W-1:0]       a_ext, b_ext, c_ext, d_ext;

    logic             s_accept, in_take, prod_load, last_next;
    logic [LEN_W-1:0] len_raw, len_eff, count_inc;

    // Clamp the configured length to 1..MAX_INTEGRATION.
    always_comb begin
        len_raw = LEN_W'(cfg_len);
        if (len_raw == '0) begin
            len_eff = ONE_LEN;
        end else if (len_raw > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = len_raw;
        end
    end

    assign count_inc = LEN_W'(count_reg) + ONE_LEN;
    assign last_next = (count_inc >= len_eff);

    assign prod_load = !prod_valid_reg || prod_take;
    assign in_take   = in_valid_reg && prod_load;
    assign s_ready   = !in_valid_reg || in_take;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_take) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (s_accept) begin
            count_next = last_next ? '0 : CNT_W'(count_inc);
        end
    end

    assign prod_valid_next = prod_load ? in_valid_reg : prod_valid_reg;

    assign a_ext = PROD_W'(a_reg);
    assign b_ext = PROD_W'(b_reg);
    assign c_ext = PROD_W'(c_reg);
    assign d_ext = PROD_W'(d_reg);

    assign prod_next[PROD_AA] = a_ext * a_ext;
    assign prod_next[PROD_BB] = b_ext * b_ext;
    assign prod_next[PROD_CC] = c_ext * c_ext;
    assign prod_next[PROD_DD] = d_ext * d_ext;
    assign prod_next[PROD_AC] = a_ext * c_ext;
    assign prod_next[PROD_BD] = b_ext * d_ext;
    assign prod_next[PROD_BC] = b_ext * c_ext;
    assign prod_next[PROD_AD] = a_ext * d_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_reg       <= s_first_pol_real;
            b_reg       <= s_first_pol_imag;
            c_reg       <= s_second_pol_real;
            d_reg       <= s_second_pol_imag;
            in_last_reg <= last_next;
        end
        if (prod_load && in_valid_reg) begin
            prod_reg      <= prod_next;
            prod_last_reg <= in_last_reg;
        end
    end

    assign prod_ctl.valid = prod_valid_reg;
    assign prod_ctl.last  = prod_last_reg;
    assign prod = prod_reg;

    `DPDI_ASSERT(a_count_range, LEN_W'(count_reg) < MAX_LEN, "sample count out of range")
    `DPDI_ASSERT_NEXT(a_count_wrap, s_accept && last_next, count_reg == '0,
        "count not cleared after closing sample")
    `DPDI_ASSERT_NEXT(a_in_hold, in_valid_reg && !prod_load,
        in_valid_reg && $stable(a_reg) && $stable(d_reg), "stalled input stage lost its item")

endmodule

`default_nettype wire

[hdl/dpdi_accum.sv]
`default_nettype none
`include "dual_pol_detect_integrate_macros.svh"

module dpdi_accum import dpdi_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int unsigned PROD_W = 2 * SAMPLE_WIDTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire stage_ctl_t               prod_ctl,
    input  wire logic signed [PROD_W-1:0] prod [NUM_PROD],
    output logic                          prod_take,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [POWER_W-1:0]            m_power_first,
    output logic [POWER_W-1:0]            m_power_second,
    output logic signed [CROSS_W-1:0]     m_cross_real,
    output logic signed [CROSS_W-1:0]     m_cross_imag
);

    localparam int unsigned EXT_W = (PROD_W + 1 > CROSS_W) ? PROD_W + 1 : CROSS_W;

    logic signed [EXT_W-1:0] ext [NUM_PROD];
    logic signed [EXT_W-1:0] pf_sum, ps_sum, cr_sum, ci_sum;
    logic [POWER_W-1:0]      pf_inc, ps_inc;
    logic [CROSS_W-1:0]      cr_inc, ci_inc;

    logic [POWER_W-1:0] acc_pf_reg, acc_ps_reg, acc_pf_next, acc_ps_next;
    logic [CROSS_W-1:0] acc_cr_reg, acc_ci_reg, acc_cr_next, acc_ci_next;
    logic [POWER_W-1:0] res_pf_reg, res_ps_reg;
    logic [CROSS_W-1:0] res_cr_reg, res_ci_reg;
    logic               m_valid_reg, m_valid_next;
    logic               close;

    for (genvar k = 0; k < NUM_PROD; k++) begin : g_ext
        assign ext[k] = {{(EXT_W - PROD_W){prod[k][PROD_W-1]}}, prod[k]};
    end

    assign pf_sum = ext[PROD_AA] + ext[PROD_BB];
    assign ps_sum = ext[PROD_CC] + ext[PROD_DD];
    assign cr_sum = ext[PROD_AC] + ext[PROD_BD];
    assign ci_sum = ext[PROD_BC] - ext[PROD_AD];

    assign pf_inc = pf_sum[POWER_W-1:0];
    assign ps_inc = ps_sum[POWER_W-1:0];
    assign cr_inc = cr_sum[CROSS_W-1:0];
    assign ci_inc = ci_sum[CROSS_W-1:0];

    assign acc_pf_next = acc_pf_reg + pf_inc;
    assign acc_ps_next = acc_ps_reg + ps_inc;
    assign acc_cr_next = acc_cr_reg + cr_inc;
    assign acc_ci_next = acc_ci_reg + ci_inc;

    // Non-closing items keep flowing while a result waits.
    assign prod_take = prod_ctl.valid && (!prod_ctl.last || !m_valid_reg || m_ready);
    assign close     = prod_take && prod_ctl.last;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (close) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_pf_reg  <= '0;
            acc_ps_reg  <= '0;
            acc_cr_reg  <= '0;
            acc_ci_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (close) begin
                acc_pf_reg <= '0;
                acc_ps_reg <= '0;
                acc_cr_reg <= '0;
                acc_ci_reg <= '0;
            end else if (prod_take) begin
                acc_pf_reg <= acc_pf_next;
                acc_ps_reg <= acc_ps_next;
                acc_cr_reg <= acc_cr_next;
                acc_ci_reg <= acc_ci_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (close) begin
            res_pf_reg <= acc_pf_next;
            res_ps_reg <= acc_ps_next;
            res_cr_reg <= acc_cr_next;
            res_ci_reg <= acc_ci_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_power_first  = res_pf_reg;
    assign m_power_second = res_ps_reg;
    assign m_cross_real   = res_cr_reg;
    assign m_cross_imag   = res_ci_reg;

    `DPDI_ASSERT_NEXT(a_close_valid, close, m_valid_reg, "closing item gave no result")
    `DPDI_ASSERT_NEXT(a_close_clear, close,
        acc_pf_reg == '0 && acc_ps_reg == '0 && acc_cr_reg == '0 && acc_ci_reg == '0,
        "accumulators not cleared after result")
    `DPDI_ASSERT_IMPL(a_no_overwrite, m_valid_reg && !m_ready, !close,
        "pending result overwritten")

endmodule

`default_nettype wire

[hdl/dual_pol_detect_integrate.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    four complex sample parts, SAMPLE_WIDTH each
// m_        out        m_valid/m_ready    two 40-bit powers, two 41-bit cross terms
// cfg_      in         cfg_wr_en          9-bit integration length
//
// One item is accepted per cycle while s_ready is high; results load on the closing item.
// Stages: input register, multiplier register, accumulator with result register.
// Reset is synchronous; accumulators, count and valids clear at once.
// Only the closing item of an integration waits on a full result register;
// other items keep accumulating while a result is held.
`default_nettype none

module dual_pol_detect_integrate import dpdi_pkg::*; #(
    parameter int unsigned SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
    parameter int unsigned MAX_INTEGRATION = MAX_INTEGRATION_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_W-1:0]               cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_first_pol_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_first_pol_imag,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_second_pol_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] s_second_pol_imag,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [POWER_W-1:0]                  m_power_first,
    output logic [POWER_W-1:0]                  m_power_second,
    output logic signed [CROSS_W-1:0]           m_cross_real,
    output logic signed [CROSS_W-1:0]           m_cross_imag
);

    localparam int unsigned PROD_W = 2 * SAMPLE_WIDTH;

    logic [CFG_W-1:0]         cfg_len_reg;
    stage_ctl_t               prod_ctl;
    logic                     prod_take;
    logic signed [PROD_W-1:0] prod [NUM_PROD];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_reg <= CFG_LEN_RESET;
        end else if (cfg_wr_en) begin
            cfg_len_reg <= cfg_wr_data;
        end
    end

    dpdi_front #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .MAX_INTEGRATION (MAX_INTEGRATION)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_len           (cfg_len_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_first_pol_real  (s_first_pol_real),
        .s_first_pol_imag  (s_first_pol_imag),
        .s_second_pol_real (s_second_pol_real),
        .s_second_pol_imag (s_second_pol_imag),
        .prod_take         (prod_take),
        .prod_ctl          (prod_ctl),
        .prod              (prod)
    );

    dpdi_accum #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_accum (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .prod_ctl       (prod_ctl),
        .prod           (prod),
        .prod_take      (prod_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_first  (m_power_first),
        .m_power_second (m_power_second),
        .m_cross_real   (m_cross_real),
        .m_cross_imag   (m_cross_imag)
    );

endmodule

`default_nettype wire
